/* rtl/tmst_pkg.sv */
// shared types and constants for the target membership state table
package tmst_pkg;

	localparam int NUM_TARGETS_DEF = 64;
	localparam int OPCODE_W = 3;
	localparam int INDEX_W = 6;
	localparam int STATUS_W = 3;
	localparam int FLAGS_W = 2;
	localparam int VER_W = 32;

	typedef enum logic [OPCODE_W-1:0] {
		OP_EXCLUDE        = 3'd0,
		OP_DRAIN          = 3'd1,
		OP_REINT          = 3'd2,
		OP_EXTEND         = 3'd3,
		OP_ADD_IN         = 3'd4,
		OP_EXCL_OUT       = 3'd5,
		OP_REBUILD_DONE   = 3'd6,
		OP_REVERT_REBUILD = 3'd7
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_NEW     = 3'd0,
		ST_UP      = 3'd1,
		ST_UPIN    = 3'd2,
		ST_DOWN    = 3'd3,
		ST_DRAIN   = 3'd4,
		ST_DOWNOUT = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		OC_NONE    = 2'd0,
		OC_CHANGED = 2'd1,
		OC_NOSUP   = 2'd2,
		OC_BUSY    = 2'd3
	} outcome_t;

	localparam logic [FLAGS_W-1:0] FL_DOWN2UP  = 2'b01;
	localparam logic [FLAGS_W-1:0] FL_DOWN2OUT = 2'b10;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [FLAGS_W-1:0]  flags;
		logic [VER_W-1:0]    fail_seq;
		logic [VER_W-1:0]    in_version;
		logic [VER_W-1:0]    out_version;
	} entry_t;

	localparam entry_t ENTRY_RESET = '{
		status:      ST_UPIN,
		flags:       '0,
		fail_seq:    '0,
		in_version:  '0,
		out_version: '0
	};

endpackage

/* rtl/target_membership_state_table.sv */
// target membership state table: one command word in, one result word out
//
// A command word is taken into a first stage while the addressed table entry is read from a
// single-port-write memory; once the output side is free, the membership transition, version
// bump and stamping are worked out and written back, and the result word is registered. One
// command word is accepted per cycle when the output side is not stalled; the result word
// comes from an output register behind the first stage. A command that follows on the same
// target in the very next cycle sees the freshly written entry through a bypass register.
// After reset the block runs a clearing pass that writes every entry to upin with zero flags
// and stamps; in_stall stays high during that pass. The map version counter starts at one
// and wraps modulo 2^32.
module target_membership_state_table
	import tmst_pkg::*;
#(
	parameter int NUM_TARGETS = NUM_TARGETS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [OPCODE_W-1:0] opcode,
	input  logic [INDEX_W-1:0]  target_index,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [1:0]          outcome,
	output logic [STATUS_W-1:0] new_status,
	output logic [FLAGS_W-1:0]  new_flags,
	output logic [VER_W-1:0]    fail_seq,
	output logic [VER_W-1:0]    in_version,
	output logic [VER_W-1:0]    out_version,
	output logic [VER_W-1:0]    map_version
);

	localparam int AW = (NUM_TARGETS > 1) ? $clog2(NUM_TARGETS) : 1;
	localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_TARGETS - 1);

	entry_t mem [NUM_TARGETS];

	logic          clr_q;
	logic [AW-1:0] clr_cnt_q;

	logic          valid_s1;
	opcode_t       op_s1;
	logic [AW-1:0] addr_s1;
	logic          in_range_s1;
	logic          fwd_hit_s1;
	entry_t        rd_s1;

	entry_t        fwd_q;
	logic [VER_W-1:0] ver_q;

	logic          out_valid_q;
	outcome_t      outcome_q;
	entry_t        res_q;
	logic [VER_W-1:0] map_ver_q;

	logic          in_acc;
	logic          out_free;
	logic          adv_s1;
	logic          in_range;
	logic [AW-1:0] in_addr;

	entry_t        cur;
	entry_t        nxt;
	outcome_t      oc;
	logic          bump;
	logic          wr_en;
	logic [VER_W-1:0] ver_inc;

	assign in_addr  = AW'(target_index);
	assign in_range = 32'(target_index) < 32'(NUM_TARGETS);
	assign out_free = !out_valid_q || !out_stall;
	assign adv_s1   = valid_s1 && out_free;
	assign in_stall = clr_q || (valid_s1 && !out_free);
	assign in_acc   = in_valid && !in_stall;
	assign wr_en    = adv_s1 && in_range_s1;
	assign ver_inc  = ver_q + VER_W'(1);

	// entry as it stands: bypass when the previous word wrote this target at the read edge
	assign cur = fwd_hit_s1 ? fwd_q : rd_s1;

	always_comb begin
		nxt  = cur;
		oc   = OC_NONE;
		bump = 1'b0;
		case (op_s1)
			OP_EXCLUDE: begin
				if (cur.status inside {ST_UP, ST_UPIN, ST_DRAIN}) begin
					nxt.status   = ST_DOWN;
					nxt.fail_seq = ver_inc;
					bump         = 1'b1;
					oc           = OC_CHANGED;
				end else if (cur.status == ST_NEW) begin
					oc = OC_NOSUP;
				end
			end
			OP_DRAIN: begin
				if (cur.status inside {ST_NEW, ST_UP}) begin
					oc = OC_BUSY;
				end else if (cur.status == ST_UPIN) begin
					nxt.status   = ST_DRAIN;
					nxt.fail_seq = ver_inc;
					bump         = 1'b1;
					oc           = OC_CHANGED;
				end
			end
			OP_REINT: begin
				if (cur.status inside {ST_NEW, ST_DRAIN}) begin
					oc = OC_BUSY;
				end else if (cur.status inside {ST_DOWN, ST_DOWNOUT}) begin
					if (cur.status == ST_DOWN)
						nxt.flags = cur.flags | FL_DOWN2UP;
					nxt.status     = ST_UP;
					nxt.in_version = ver_inc;
					bump           = 1'b1;
					oc             = OC_CHANGED;
				end
			end
			OP_EXTEND: begin
				if (cur.status == ST_NEW) begin
					nxt.status     = ST_UP;
					nxt.in_version = ver_inc;
					bump           = 1'b1;
					oc             = OC_CHANGED;
				end else if (cur.status inside {ST_DOWN, ST_DRAIN, ST_DOWNOUT}) begin
					oc = OC_BUSY;
				end
			end
			OP_ADD_IN, OP_EXCL_OUT, OP_REBUILD_DONE: begin
				if ((op_s1 != OP_ADD_IN) && (cur.status inside {ST_DOWN, ST_DRAIN})) begin
					if (cur.status == ST_DOWN)
						nxt.flags = FL_DOWN2OUT;
					nxt.status      = ST_DOWNOUT;
					nxt.out_version = ver_inc;
					bump            = 1'b1;
					oc              = OC_CHANGED;
				end else if ((op_s1 != OP_EXCL_OUT) && cur.status == ST_UP) begin
					nxt.flags      = '0;
					nxt.status     = ST_UPIN;
					nxt.in_version = ver_inc;
					bump           = 1'b1;
					oc             = OC_CHANGED;
				end
			end
			OP_REVERT_REBUILD: begin
				if (cur.status == ST_DRAIN) begin
					nxt.status   = ST_UPIN;
					nxt.fail_seq = '0;
					bump         = 1'b1;
					oc           = OC_CHANGED;
				end else if (cur.status == ST_UP) begin
					// an up entry whose fail_seq stamp equals one goes back to new
					if (cur.fail_seq == VER_W'(1)) begin
						nxt.status     = ST_NEW;
						nxt.in_version = '0;
					end else begin
						nxt.status      = cur.flags[0] ? ST_DOWN : ST_DOWNOUT;
						nxt.out_version = ver_inc;
					end
					bump = 1'b1;
					oc   = OC_CHANGED;
				end
			end
			default: begin
				oc = OC_NONE;
			end
		endcase
	end

	// table memory: one write port, registered read on accept
	always_ff @(posedge clk) begin
		if (clr_q)
			mem[clr_cnt_q] <= ENTRY_RESET;
		else if (wr_en)
			mem[addr_s1] <= nxt;
		if (in_acc)
			rd_s1 <= mem[in_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clr_q) begin
			clr_cnt_q <= clr_cnt_q + AW'(1);
			if (clr_cnt_q == LAST_ADDR)
				clr_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			ver_q       <= VER_W'(1);
		end else begin
			if (in_acc)
				valid_s1 <= 1'b1;
			else if (adv_s1)
				valid_s1 <= 1'b0;
			if (adv_s1)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			if (wr_en && bump)
				ver_q <= ver_inc;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_s1       <= opcode_t'(opcode);
			addr_s1     <= in_addr;
			in_range_s1 <= in_range;
			fwd_hit_s1  <= wr_en && (addr_s1 == in_addr);
		end
		if (wr_en)
			fwd_q <= nxt;
		if (adv_s1) begin
			if (in_range_s1) begin
				outcome_q <= oc;
				res_q     <= nxt;
				map_ver_q <= bump ? ver_inc : ver_q;
			end else begin
				outcome_q <= OC_NOSUP;
				res_q     <= '0;
				map_ver_q <= ver_q;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign outcome     = outcome_q;
	assign new_status  = res_q.status;
	assign new_flags   = res_q.flags;
	assign fail_seq    = res_q.fail_seq;
	assign in_version  = res_q.in_version;
	assign out_version = res_q.out_version;
	assign map_version = map_ver_q;

endmodule

/* sim/tb_top.sv */
// testbench for the target membership state table: table-driven and random command words
`timescale 1ns / 1ps

module tb_top;
	import tmst_pkg::*;

	localparam int QUIET_LIMIT = 3000;
	localparam int N_DIRECTED = 25;

	typedef struct packed {
		outcome_t            outcome;
		status_t             status;
		logic [FLAGS_W-1:0]  flags;
		logic [VER_W-1:0]    fail_seq;
		logic [VER_W-1:0]    in_ver;
		logic [VER_W-1:0]    out_ver;
		logic [VER_W-1:0]    map_ver;
	} membership_result_t;

	typedef struct packed {
		opcode_t             op;
		logic [INDEX_W-1:0]  idx;
		logic                has_want;
		membership_result_t  want;
	} directed_row_t;

	localparam membership_result_t NO_WANT = '0;

	// words 0..7 hit every opcode right after reset, the rest walk targets 0 and 63
	// through every status but new and are checked against the predictor
	directed_row_t directed_rows [0:N_DIRECTED-1] = '{
		'{OP_DRAIN, 6'd63, 1'b1, '{OC_CHANGED, ST_DRAIN, 2'b00, 32'd2, 32'd0, 32'd0, 32'd2}},
		'{OP_EXCLUDE, 6'd0, 1'b1, '{OC_CHANGED, ST_DOWN, 2'b00, 32'd3, 32'd0, 32'd0, 32'd3}},
		'{OP_ADD_IN, 6'd1, 1'b1, '{OC_NONE, ST_UPIN, 2'b00, 32'd0, 32'd0, 32'd0, 32'd3}},
		'{OP_REINT, 6'd2, 1'b1, '{OC_NONE, ST_UPIN, 2'b00, 32'd0, 32'd0, 32'd0, 32'd3}},
		'{OP_EXTEND, 6'd3, 1'b1, '{OC_NONE, ST_UPIN, 2'b00, 32'd0, 32'd0, 32'd0, 32'd3}},
		'{OP_REVERT_REBUILD, 6'd4, 1'b1,
			'{OC_NONE, ST_UPIN, 2'b00, 32'd0, 32'd0, 32'd0, 32'd3}},
		'{OP_EXCL_OUT, 6'd5, 1'b1, '{OC_NONE, ST_UPIN, 2'b00, 32'd0, 32'd0, 32'd0, 32'd3}},
		'{OP_REBUILD_DONE, 6'd6, 1'b1,
			'{OC_NONE, ST_UPIN, 2'b00, 32'd0, 32'd0, 32'd0, 32'd3}},
		'{OP_DRAIN, 6'd0, 1'b0, NO_WANT},
		'{OP_EXTEND, 6'd0, 1'b0, NO_WANT},
		'{OP_REINT, 6'd0, 1'b0, NO_WANT},
		'{OP_DRAIN, 6'd0, 1'b0, NO_WANT},
		'{OP_REVERT_REBUILD, 6'd0, 1'b0, NO_WANT},
		'{OP_EXCL_OUT, 6'd0, 1'b0, NO_WANT},
		'{OP_EXCLUDE, 6'd0, 1'b0, NO_WANT},
		'{OP_REINT, 6'd0, 1'b0, NO_WANT},
		'{OP_REVERT_REBUILD, 6'd0, 1'b0, NO_WANT},
		'{OP_REINT, 6'd0, 1'b0, NO_WANT},
		'{OP_REBUILD_DONE, 6'd0, 1'b0, NO_WANT},
		'{OP_REINT, 6'd63, 1'b0, NO_WANT},
		'{OP_REVERT_REBUILD, 6'd63, 1'b0, NO_WANT},
		'{OP_DRAIN, 6'd63, 1'b0, NO_WANT},
		'{OP_REBUILD_DONE, 6'd63, 1'b0, NO_WANT},
		'{OP_REINT, 6'd63, 1'b0, NO_WANT},
		'{OP_ADD_IN, 6'd63, 1'b0, NO_WANT}
	};

	int unsigned idle_pct_tab [0:2] = '{25, 83, 0};
	int unsigned stall_pct_tab [0:2] = '{83, 25, 0};
	int unsigned random_count_tab [0:2] = '{600, 625, 625};

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [OPCODE_W-1:0] opcode = '0;
	logic [INDEX_W-1:0]  target_index = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [1:0]          outcome;
	logic [STATUS_W-1:0] new_status;
	logic [FLAGS_W-1:0]  new_flags;
	logic [VER_W-1:0]    fail_seq;
	logic [VER_W-1:0]    in_version;
	logic [VER_W-1:0]    out_version;
	logic [VER_W-1:0]    map_version;

	logic                word_has_want = 1'b0;
	membership_result_t  word_want = '0;

	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int n_words = 0;
	int n_results = 0;
	int n_errors = 0;
	int quiet_cycles = 0;

	// predictor copy of the table and the version counter
	status_t            member_status [NUM_TARGETS_DEF];
	logic [FLAGS_W-1:0] member_flags [NUM_TARGETS_DEF];
	logic [VER_W-1:0]   member_fail_seq [NUM_TARGETS_DEF];
	logic [VER_W-1:0]   member_in_ver [NUM_TARGETS_DEF];
	logic [VER_W-1:0]   member_out_ver [NUM_TARGETS_DEF];
	logic [VER_W-1:0]   map_ver;

	membership_result_t pending_results [$];

	target_membership_state_table uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.target_index(target_index),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.outcome(outcome),
		.new_status(new_status),
		.new_flags(new_flags),
		.fail_seq(fail_seq),
		.in_version(in_version),
		.out_version(out_version),
		.map_version(map_version)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	function automatic membership_result_t apply_command(opcode_t op, int unsigned t);
		membership_result_t r;
		status_t st;
		outcome_t oc;
		if (t >= NUM_TARGETS_DEF) begin
			r = '0;
			r.outcome = OC_NOSUP;
			r.map_ver = map_ver;
			return r;
		end
		st = member_status[t];
		oc = OC_NONE;
		case (op)
			OP_EXCLUDE: begin
				if (st == ST_UP || st == ST_UPIN || st == ST_DRAIN) begin
					member_status[t] = ST_DOWN;
					map_ver = map_ver + 1;
					member_fail_seq[t] = map_ver;
					oc = OC_CHANGED;
				end else if (st == ST_NEW) begin
					oc = OC_NOSUP;
				end
			end
			OP_DRAIN: begin
				if (st == ST_NEW || st == ST_UP) begin
					oc = OC_BUSY;
				end else if (st == ST_UPIN) begin
					member_status[t] = ST_DRAIN;
					map_ver = map_ver + 1;
					member_fail_seq[t] = map_ver;
					oc = OC_CHANGED;
				end
			end
			OP_REINT: begin
				if (st == ST_NEW || st == ST_DRAIN) begin
					oc = OC_BUSY;
				end else if (st == ST_DOWN || st == ST_DOWNOUT) begin
					if (st == ST_DOWN)
						member_flags[t] = member_flags[t] | FL_DOWN2UP;
					member_status[t] = ST_UP;
					map_ver = map_ver + 1;
					member_in_ver[t] = map_ver;
					oc = OC_CHANGED;
				end
			end
			OP_EXTEND: begin
				if (st == ST_NEW) begin
					member_status[t] = ST_UP;
					map_ver = map_ver + 1;
					member_in_ver[t] = map_ver;
					oc = OC_CHANGED;
				end else if (st == ST_DOWN || st == ST_DRAIN || st == ST_DOWNOUT) begin
					oc = OC_BUSY;
				end
			end
			OP_ADD_IN, OP_EXCL_OUT, OP_REBUILD_DONE: begin
				// rebuild done takes a target out from down/drain and adds it in from up
				if ((st == ST_DOWN || st == ST_DRAIN) && op != OP_ADD_IN) begin
					if (st == ST_DOWN)
						member_flags[t] = FL_DOWN2OUT;
					member_status[t] = ST_DOWNOUT;
					map_ver = map_ver + 1;
					member_out_ver[t] = map_ver;
					oc = OC_CHANGED;
				end else if (st == ST_UP && op != OP_EXCL_OUT) begin
					member_flags[t] = '0;
					map_ver = map_ver + 1;
					member_in_ver[t] = map_ver;
					member_status[t] = ST_UPIN;
					oc = OC_CHANGED;
				end
			end
			default: begin
				if (st == ST_DRAIN) begin
					member_status[t] = ST_UPIN;
					member_fail_seq[t] = '0;
					map_ver = map_ver + 1;
					oc = OC_CHANGED;
				end else if (st == ST_UP) begin
					if (member_fail_seq[t] == 32'd1) begin
						member_status[t] = ST_NEW;
						member_in_ver[t] = '0;
						map_ver = map_ver + 1;
					end else begin
						member_status[t] = (member_flags[t] & FL_DOWN2UP) ? ST_DOWN : ST_DOWNOUT;
						map_ver = map_ver + 1;
						member_out_ver[t] = map_ver;
					end
					oc = OC_CHANGED;
				end
			end
		endcase
		r.outcome = oc;
		r.status = member_status[t];
		r.flags = member_flags[t];
		r.fail_seq = member_fail_seq[t];
		r.in_ver = member_in_ver[t];
		r.out_ver = member_out_ver[t];
		r.map_ver = map_ver;
		return r;
	endfunction

	// an opcode that moves a target out of its present status
	function automatic opcode_t useful_op(status_t st);
		case (st)
			ST_NEW: return OP_EXTEND;
			ST_UP: begin
				case ($urandom_range(3))
					0: return OP_EXCLUDE;
					1: return OP_ADD_IN;
					2: return OP_REBUILD_DONE;
					default: return OP_REVERT_REBUILD;
				endcase
			end
			ST_UPIN: return $urandom_range(1) ? OP_EXCLUDE : OP_DRAIN;
			ST_DOWN: begin
				case ($urandom_range(2))
					0: return OP_REINT;
					1: return OP_EXCL_OUT;
					default: return OP_REBUILD_DONE;
				endcase
			end
			ST_DRAIN: begin
				case ($urandom_range(3))
					0: return OP_EXCLUDE;
					1: return OP_EXCL_OUT;
					2: return OP_REBUILD_DONE;
					default: return OP_REVERT_REBUILD;
				endcase
			end
			default: return OP_REINT;
		endcase
	endfunction

	task automatic check_field(string name, logic [VER_W-1:0] want, logic [VER_W-1:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			n_errors++;
		end
	endtask

	task automatic send_word(opcode_t op, logic [INDEX_W-1:0] idx, logic has_want,
		membership_result_t want);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		target_index <= idx;
		word_has_want <= has_want;
		word_want <= want;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	always @(posedge clk) begin : monitor
		membership_result_t want;
		membership_result_t predicted;
		logic moved;
		moved = 1'b0;
		if (out_valid === 1'b1 && !out_stall) begin
			moved = 1'b1;
			n_results++;
			if (pending_results.size() == 0) begin
				$error("result word with no command outstanding");
				n_errors++;
			end else begin
				want = pending_results.pop_front();
				check_field("outcome", want.outcome, outcome);
				check_field("new_status", want.status, new_status);
				check_field("new_flags", want.flags, new_flags);
				check_field("fail_seq", want.fail_seq, fail_seq);
				check_field("in_version", want.in_ver, in_version);
				check_field("out_version", want.out_ver, out_version);
				check_field("map_version", want.map_ver, map_version);
			end
		end
		if (arst_n && in_valid && in_stall === 1'b0) begin
			moved = 1'b1;
			n_words++;
			predicted = apply_command(opcode_t'(opcode), target_index);
			pending_results.push_back(word_has_want ? word_want : predicted);
		end
		quiet_cycles = moved ? 0 : quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("watchdog: no word moved for %0d cycles", QUIET_LIMIT);
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		logic [INDEX_W-1:0] t;
		opcode_t op;
		for (int i = 0; i < NUM_TARGETS_DEF; i++) begin
			member_status[i] = ST_UPIN;
			member_flags[i] = '0;
			member_fail_seq[i] = '0;
			member_in_ver[i] = '0;
			member_out_ver[i] = '0;
		end
		map_ver = 32'd1;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = idle_pct_tab[ph];
			recv_stall_pct = stall_pct_tab[ph];
			if (ph == 0) begin
				foreach (directed_rows[i])
					send_word(directed_rows[i].op, directed_rows[i].idx,
						directed_rows[i].has_want, directed_rows[i].want);
			end
			repeat (random_count_tab[ph]) begin
				// a small hot set keeps targets moving through long histories
				t = ($urandom_range(99) < 60) ? INDEX_W'($urandom_range(7))
					: INDEX_W'($urandom_range(NUM_TARGETS_DEF - 1));
				op = ($urandom_range(99) < 75) ? useful_op(member_status[t])
					: opcode_t'($urandom_range(7));
				send_word(op, t, 1'b0, NO_WANT);
			end
			// hold off until the pipe has drained
			in_valid <= 1'b0;
			do
				@(negedge clk);
			while (pending_results.size() != 0);
		end
		repeat (8) @(posedge clk);
		$display("covered %0d command words over three idle/stall mixes, %0d results compared",
			n_words, n_results);
		$display("table walked through up, upin, down, drain and downout; %0d mismatches",
			n_errors);
		if (n_errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
